### design/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared widths, field positions, status and command codes, the command word
// that travels from the front end to the back end, and the lowest-bit finder.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int SLOTS_DEFAULT = 512;

    localparam int BASE_W       = 48;
    localparam int SIZE_W       = 16;
    localparam int ADDR_W       = 49;
    localparam int OFFSET_W     = 49;
    localparam int STATUS_W     = 3;
    localparam int SLOT_FIELD_W = 9;
    localparam int FREE_FIELD_W = 10;

    // Stream word layouts, lowest field first.
    localparam int IN_TDATA_W   = 72;
    localparam int IN_SIZE_LSB  = 0;
    localparam int IN_ADDR_LSB  = IN_SIZE_LSB + SIZE_W;
    localparam int IN_USED_W    = IN_ADDR_LSB + ADDR_W;

    localparam int OUT_TDATA_W    = 72;
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_GRANT_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_SLOT_LSB   = OUT_GRANT_LSB + ADDR_W;
    localparam int OUT_FREE_LSB   = OUT_SLOT_LSB + SLOT_FIELD_W;
    localparam int OUT_USED_W     = OUT_FREE_LSB + FREE_FIELD_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 48;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_BYTES   = 1'd1;
    localparam logic [SIZE_W-1:0]      SLOT_BYTES_RESET = 16'd64;

    // Request kinds carried in tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_MISMATCH,
        CMD_INVALID
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [OFFSET_W-1:0]   offset;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [31:0] MASK_ODD  = 32'h55555555;
    localparam logic [31:0] MASK_PAIR = 32'h33333333;
    localparam logic [31:0] MASK_NIB  = 32'h0F0F0F0F;
    localparam logic [31:0] MASK_BYTE = 32'h00FF00FF;
    localparam logic [31:0] MASK_HALF = 32'h0000FFFF;

    // Position of the lowest set bit of a bitmap word (0 when the word is 0).
    function automatic logic [4:0] lowest_set_bit(input logic [31:0] map_word);
        logic [31:0] iso;
        logic [4:0]  idx;
        iso    = map_word & (~map_word + 32'd1);
        idx[0] = |(iso & ~MASK_ODD);
        idx[1] = |(iso & ~MASK_PAIR);
        idx[2] = |(iso & ~MASK_NIB);
        idx[3] = |(iso & ~MASK_BYTE);
        idx[4] = |(iso & ~MASK_HALF);
        return idx;
    endfunction

endpackage
`default_nettype wire

### design/bsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator front end
// Accepts request words, checks the size and the lower pool bound, and turns
// each request into a command for the queue.
// ----------------------------------------------------------------------------
module bsa_front
(
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          operation,
    input  wire logic [bsa_pkg::SIZE_W-1:0]    request_size,
    input  wire logic [bsa_pkg::ADDR_W-1:0]    release_address,
    input  wire logic [bsa_pkg::BASE_W-1:0]    base_address,
    input  wire logic [bsa_pkg::SIZE_W-1:0]    slot_bytes,
    input  wire bsa_pkg::queue_status_t        queue_status,
    output logic                               push,
    output bsa_pkg::cmd_t                      cmd
);

    logic [bsa_pkg::OFFSET_W:0] offset;

    // One extra bit catches an address below the pool base as a borrow.
    assign offset = {1'b0, release_address} - {2'b00, base_address};

    assign s_tready = !queue_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        cmd.offset = offset[bsa_pkg::OFFSET_W-1:0];
        if (operation == bsa_pkg::OP_ALLOC)
        begin
            cmd.kind = (request_size == slot_bytes) ? bsa_pkg::CMD_ALLOC
                                                    : bsa_pkg::CMD_MISMATCH;
        end
        else
        begin
            cmd.kind = offset[bsa_pkg::OFFSET_W] ? bsa_pkg::CMD_INVALID
                                                 : bsa_pkg::CMD_FREE;
        end
    end

endmodule
`default_nettype wire

### design/bsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module bsa_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire bsa_pkg::cmd_t          cmd_in,
    input  wire logic                   pop,
    output bsa_pkg::cmd_t               cmd_out,
    output bsa_pkg::queue_status_t      queue_status
);

    localparam int DEPTH = bsa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bsa_pkg::cmd_t      entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign queue_status.full  = (count_reg == FULL_CNT);
    assign queue_status.empty = (count_reg == '0);
    assign cmd_out            = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### design/bsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator back end
// Executes commands against the free bitmap: word scan for allocation,
// restoring division and read-modify-write for release, result register.
// ----------------------------------------------------------------------------
module bsa_back
#(
    parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [bsa_pkg::BASE_W-1:0]          base_address,
    input  wire logic [bsa_pkg::SIZE_W-1:0]          slot_bytes,
    input  wire bsa_pkg::queue_status_t              queue_status,
    input  wire bsa_pkg::cmd_t                       cmd,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [bsa_pkg::STATUS_W-1:0]             status,
    output logic [bsa_pkg::ADDR_W-1:0]               granted_address,
    output logic [bsa_pkg::SLOT_FIELD_W-1:0]         slot_index,
    output logic [bsa_pkg::FREE_FIELD_W-1:0]         free_slots
);

    localparam int MAP_WORDS = (SLOTS + 31) / 32;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int DIV_W     = bsa_pkg::SIZE_W + SLOT_W;
    localparam int STEP_W    = $clog2(SLOT_W);
    localparam int TAIL_BITS = SLOTS % 32;
    localparam logic [31:0] LAST_MASK =
        (TAIL_BITS == 0) ? 32'hFFFFFFFF : ((32'd1 << TAIL_BITS) - 32'd1);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(SLOTS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOT_W - 1);
    localparam logic [DIV_W-1:0]  SLOTS_EXT = DIV_W'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FCHECK,
        S_DIV,
        S_FREAD,
        S_FUPD,
        S_SCAN,
        S_AMUL,
        S_AADD,
        S_RESP
    } state_t;

    state_t                          state_reg;
    logic [bsa_pkg::OFFSET_W-1:0]    offset_reg;
    logic [DIV_W-1:0]                span_reg;
    logic [DIV_W-1:0]                rem_reg;
    logic [DIV_W-1:0]                div_reg;
    logic [SLOT_W-1:0]               quo_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [WORD_W-1:0]               iss_reg;
    logic                            iss_done_reg;
    logic                            rdv_reg;
    logic [SLOT_W-1:0]               slot_reg;
    logic [DIV_W-1:0]                prod_reg;
    logic [bsa_pkg::STATUS_W-1:0]    res_status_reg;
    logic [bsa_pkg::ADDR_W-1:0]      res_granted_reg;
    logic [CNT_W-1:0]                free_total_reg;
    logic [MAP_WORDS-1:0]            word_valid_reg;
    logic                            out_valid_reg;
    logic [bsa_pkg::STATUS_W-1:0]    out_status_reg;
    logic [bsa_pkg::ADDR_W-1:0]      out_granted_reg;
    logic [bsa_pkg::SLOT_FIELD_W-1:0] out_slot_reg;
    logic [bsa_pkg::FREE_FIELD_W-1:0] out_free_reg;

    // Bitmap memory: one write and one registered read per cycle.
    logic [31:0]        map_mem [MAP_WORDS];
    logic [31:0]        rd_data_reg;
    logic               rd_vld_reg;
    logic [WORD_W-1:0]  rd_tag_reg;

    logic [31:0]        map_word;
    logic [4:0]         bit_sel;
    logic [4:0]         found_bit;
    logic [WORD_W-1:0]  quo_word;
    logic               mem_re;
    logic [WORD_W-1:0]  mem_raddr;
    logic               mem_we;
    logic [31:0]        mem_wdata;
    logic               rem_ge;
    logic               out_free;
    logic               load_out;

    // A word never written since reset reads as its reset image.
    assign map_word  = rd_vld_reg ? rd_data_reg
                                  : ((rd_tag_reg == LAST_WORD) ? LAST_MASK : 32'hFFFFFFFF);
    assign bit_sel   = quo_reg[4:0];
    assign found_bit = bsa_pkg::lowest_set_bit(map_word);
    assign quo_word  = WORD_W'(quo_reg >> 5);
    assign rem_ge    = (rem_reg >= div_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign load_out  = (state_reg == S_RESP) && out_free;
    assign pop       = (state_reg == S_IDLE) && !queue_status.empty;

    assign mem_re    = ((state_reg == S_SCAN) && !iss_done_reg) || (state_reg == S_FREAD);
    assign mem_raddr = (state_reg == S_FREAD) ? quo_word : iss_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = map_word;
        if ((state_reg == S_SCAN) && rdv_reg && (map_word != '0))
        begin
            mem_we    = 1'b1;
            mem_wdata = map_word & ~(32'd1 << found_bit);
        end
        else if ((state_reg == S_FUPD) && !map_word[bit_sel])
        begin
            mem_we    = 1'b1;
            mem_wdata = map_word | (32'd1 << bit_sel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[rd_tag_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
            rd_vld_reg  <= word_valid_reg[mem_raddr];
            rd_tag_reg  <= mem_raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            offset_reg      <= '0;
            span_reg        <= '0;
            rem_reg         <= '0;
            div_reg         <= '0;
            quo_reg         <= '0;
            step_reg        <= '0;
            iss_reg         <= '0;
            iss_done_reg    <= 1'b0;
            rdv_reg         <= 1'b0;
            slot_reg        <= '0;
            prod_reg        <= '0;
            res_status_reg  <= bsa_pkg::ST_OK;
            res_granted_reg <= '0;
            free_total_reg  <= CNT_RESET;
            word_valid_reg  <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= bsa_pkg::ST_OK;
            out_granted_reg <= '0;
            out_slot_reg    <= '0;
            out_free_reg    <= '0;
        end
        else
        begin
            span_reg <= DIV_W'(slot_bytes) * SLOTS_EXT;

            if (mem_we)
            begin
                word_valid_reg[rd_tag_reg] <= 1'b1;
            end

            // A new result may replace the one taken at this same edge.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        offset_reg      <= cmd.offset;
                        iss_reg         <= '0;
                        iss_done_reg    <= 1'b0;
                        rdv_reg         <= 1'b0;
                        quo_reg         <= '0;
                        slot_reg        <= '0;
                        res_granted_reg <= '0;
                        unique case (cmd.kind)
                            bsa_pkg::CMD_ALLOC:    state_reg <= S_SCAN;
                            bsa_pkg::CMD_FREE:     state_reg <= S_FCHECK;
                            bsa_pkg::CMD_MISMATCH:
                            begin
                                res_status_reg <= bsa_pkg::ST_MISMATCH;
                                state_reg      <= S_RESP;
                            end
                            bsa_pkg::CMD_INVALID:
                            begin
                                res_status_reg <= bsa_pkg::ST_INVALID;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end

                S_FCHECK:
                begin
                    // A zero object size gives an empty span, so every release fails here.
                    if (offset_reg < bsa_pkg::OFFSET_W'(span_reg))
                    begin
                        rem_reg   <= DIV_W'(offset_reg);
                        div_reg   <= DIV_W'(slot_bytes) << (SLOT_W - 1);
                        step_reg  <= LAST_STEP;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        res_status_reg <= bsa_pkg::ST_INVALID;
                        state_reg      <= S_RESP;
                    end
                end

                S_DIV:
                begin
                    if (rem_ge)
                    begin
                        rem_reg <= rem_reg - div_reg;
                    end
                    quo_reg <= {quo_reg[SLOT_W-2:0], rem_ge};
                    div_reg <= div_reg >> 1;
                    if (step_reg == '0)
                    begin
                        state_reg <= S_FREAD;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end

                S_FREAD:
                begin
                    state_reg <= S_FUPD;
                end

                S_FUPD:
                begin
                    if (map_word[bit_sel])
                    begin
                        res_status_reg <= bsa_pkg::ST_DOUBLE;
                    end
                    else
                    begin
                        res_status_reg <= bsa_pkg::ST_OK;
                        slot_reg       <= quo_reg;
                        free_total_reg <= free_total_reg + 1'b1;
                    end
                    state_reg <= S_RESP;
                end

                S_SCAN:
                begin
                    // Reads are issued one word per cycle; each is checked in the cycle after it is issued.
                    if (!iss_done_reg)
                    begin
                        rdv_reg <= 1'b1;
                        if (iss_reg == LAST_WORD)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else
                        begin
                            iss_reg <= iss_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rdv_reg <= 1'b0;
                    end

                    if (rdv_reg)
                    begin
                        if (map_word != '0)
                        begin
                            slot_reg       <= SLOT_W'({rd_tag_reg, found_bit});
                            free_total_reg <= free_total_reg - 1'b1;
                            res_status_reg <= bsa_pkg::ST_OK;
                            state_reg      <= S_AMUL;
                        end
                        else if (rd_tag_reg == LAST_WORD)
                        begin
                            res_status_reg <= bsa_pkg::ST_FULL;
                            state_reg      <= S_RESP;
                        end
                    end
                end

                S_AMUL:
                begin
                    prod_reg  <= DIV_W'(slot_reg) * DIV_W'(slot_bytes);
                    state_reg <= S_AADD;
                end

                S_AADD:
                begin
                    res_granted_reg <= {1'b0, base_address} + bsa_pkg::ADDR_W'(prod_reg);
                    state_reg       <= S_RESP;
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_status_reg  <= res_status_reg;
                        out_granted_reg <= res_granted_reg;
                        out_slot_reg    <= bsa_pkg::SLOT_FIELD_W'(slot_reg);
                        out_free_reg    <= bsa_pkg::FREE_FIELD_W'(free_total_reg);
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = out_granted_reg;
    assign slot_index      = out_slot_reg;
    assign free_slots      = out_free_reg;

endmodule
`default_nettype wire

### design/bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator core
// First-fit allocator for one pool of equal-sized slots tracked by a free
// bitmap, with a stream request port, a stream result port and two registers.
// ----------------------------------------------------------------------------
// Each request word (tuser 0 = allocate, 1 = free) yields exactly one result
// word. An allocate whose size equals the slot size register claims the lowest
// free slot and returns base_address + slot * slot size; a free maps the
// address back to its slot by a restoring division, one quotient bit per
// cycle. The front end takes request words into a two-entry command queue
// while the back end works, so intake stops only once both queue entries are
// taken, for instance while a result waits in the output register. The back
// end handles one request at a time. An allocate scans the bitmap, reading one
// 32-bit word per cycle from the bitmap memory, until it finds a free slot or
// has checked the last word. A free runs the divider, then reads the bitmap
// word of its slot and marks the slot free. Size mismatches and addresses
// below the base go straight from the idle state to the result. The bitmap
// needs no clearing pass after reset: a valid flag per word makes a word that
// was never written read as all free. Registers may be written only while no
// request is in flight.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core
#(
    parameter int SLOTS = bsa_pkg::SLOTS_DEFAULT
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [15:0] request_size, [64:16] release_address, [71:65] zero
    input  wire logic [bsa_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [0] operation
    input  wire logic                                 s_tuser,

    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [2:0] status, [51:3] granted_address, [60:52] slot_index,
    // [70:61] free_slots, [71] zero
    output logic [bsa_pkg::OUT_TDATA_W-1:0]           m_tdata,

    input  wire logic                                 cfg_we,
    input  wire logic [bsa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bsa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [bsa_pkg::BASE_W-1:0]        base_address_reg;
    logic [bsa_pkg::SIZE_W-1:0]        slot_bytes_reg;

    bsa_pkg::queue_status_t            queue_status;
    bsa_pkg::cmd_t                     front_cmd;
    bsa_pkg::cmd_t                     back_cmd;
    logic                              push;
    logic                              pop;

    logic [bsa_pkg::STATUS_W-1:0]      status;
    logic [bsa_pkg::ADDR_W-1:0]        granted_address;
    logic [bsa_pkg::SLOT_FIELD_W-1:0]  slot_index;
    logic [bsa_pkg::FREE_FIELD_W-1:0]  free_slots;

    // Configuration registers; an index outside the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            slot_bytes_reg   <= bsa_pkg::SLOT_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bsa_pkg::CFG_BASE_ADDRESS)
            begin
                base_address_reg <= cfg_data[bsa_pkg::BASE_W-1:0];
            end
            else if (cfg_index == bsa_pkg::CFG_SLOT_BYTES)
            begin
                slot_bytes_reg <= cfg_data[bsa_pkg::SIZE_W-1:0];
            end
        end
    end

    bsa_front u_front
    (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .operation       (s_tuser),
        .request_size    (s_tdata[bsa_pkg::IN_ADDR_LSB-1:bsa_pkg::IN_SIZE_LSB]),
        .release_address (s_tdata[bsa_pkg::IN_USED_W-1:bsa_pkg::IN_ADDR_LSB]),
        .base_address    (base_address_reg),
        .slot_bytes      (slot_bytes_reg),
        .queue_status    (queue_status),
        .push            (push),
        .cmd             (front_cmd)
    );

    bsa_queue u_queue
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .cmd_in          (front_cmd),
        .pop             (pop),
        .cmd_out         (back_cmd),
        .queue_status    (queue_status)
    );

    bsa_back
    #(
        .SLOTS           (SLOTS)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .base_address    (base_address_reg),
        .slot_bytes      (slot_bytes_reg),
        .queue_status    (queue_status),
        .cmd             (back_cmd),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .status          (status),
        .granted_address (granted_address),
        .slot_index      (slot_index),
        .free_slots      (free_slots)
    );

    assign m_tdata = {
        {(bsa_pkg::OUT_TDATA_W - bsa_pkg::OUT_USED_W){1'b0}},
        free_slots,
        slot_index,
        granted_address,
        status
    };

endmodule
`default_nettype wire

### design/bsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap slot allocator port checker
// Watches the result port of the allocator core and flags results that break
// the rules of its status codes or of the stream handshake.
// ----------------------------------------------------------------------------
module bsa_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [bsa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [bsa_pkg::STATUS_W-1:0]      res_status;
    logic [bsa_pkg::ADDR_W-1:0]        res_granted;
    logic [bsa_pkg::SLOT_FIELD_W-1:0]  res_slot;
    logic [bsa_pkg::FREE_FIELD_W-1:0]  res_free;

    assign res_status  = m_tdata[bsa_pkg::OUT_GRANT_LSB-1:bsa_pkg::OUT_STATUS_LSB];
    assign res_granted = m_tdata[bsa_pkg::OUT_SLOT_LSB-1:bsa_pkg::OUT_GRANT_LSB];
    assign res_slot    = m_tdata[bsa_pkg::OUT_FREE_LSB-1:bsa_pkg::OUT_SLOT_LSB];
    assign res_free    = m_tdata[bsa_pkg::OUT_USED_W-1:bsa_pkg::OUT_FREE_LSB];

    // Only the five defined status codes ever leave the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status <= bsa_pkg::ST_DOUBLE))
        else $error("result carries an undefined status code");

    // A rejected request neither grants an address nor names a slot.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status != bsa_pkg::ST_OK)) |->
            ((res_granted == '0) && (res_slot == '0)))
        else $error("error result carries a nonzero address or slot");

    // A full pool has no free slot left to report.
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == bsa_pkg::ST_FULL)) |-> (res_free == '0))
        else $error("pool full reported with free slots remaining");

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed or dropped while stalled");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator core testbench
// Drives allocate and free request words into the core and predicts every
// result word from a private copy of the pool: the free bitmap, the free
// count and both registers. Each result word is checked field by field
// against the oldest prediction, under random idling on both streams.
// ----------------------------------------------------------------------------

// One predicted result word, split into its fields.
typedef struct {
    logic [bsa_pkg::STATUS_W-1:0]     status;
    logic [bsa_pkg::ADDR_W-1:0]       granted;
    logic [bsa_pkg::SLOT_FIELD_W-1:0] slot;
    logic [bsa_pkg::FREE_FIELD_W-1:0] free_slots;
} pool_result_t;

// Keeps the expected pool state and the results still owed by the core.
class pool_checker;
    bit [bsa_pkg::SLOTS_DEFAULT-1:0] free_map;
    int unsigned                     free_total;
    logic [bsa_pkg::BASE_W-1:0]      base_address;
    logic [bsa_pkg::SIZE_W-1:0]      slot_bytes;
    pool_result_t                    awaited[$];
    int unsigned                     errors;

    function new();
        free_map     = '1;
        free_total   = bsa_pkg::SLOTS_DEFAULT;
        base_address = '0;
        slot_bytes   = bsa_pkg::SLOT_BYTES_RESET;
        errors       = 0;
    endfunction

    function void write_reg(logic [bsa_pkg::CFG_INDEX_W-1:0] index,
                            logic [bsa_pkg::CFG_DATA_W-1:0] data);
        if (index == bsa_pkg::CFG_BASE_ADDRESS)
            base_address = data[bsa_pkg::BASE_W-1:0];
        else if (index == bsa_pkg::CFG_SLOT_BYTES)
            slot_bytes = data[bsa_pkg::SIZE_W-1:0];
    endfunction

    // Applies one accepted request to the pool and queues the result it owes.
    function void note_request(logic op, logic [bsa_pkg::SIZE_W-1:0] size,
                               logic [bsa_pkg::ADDR_W-1:0] addr);
        pool_result_t r;
        logic [63:0]  offset;
        logic [63:0]  span;
        int           s;
        r.status  = bsa_pkg::ST_OK;
        r.granted = '0;
        r.slot    = '0;
        s         = -1;
        if (op == bsa_pkg::OP_ALLOC)
        begin
            if (size != slot_bytes)
            begin
                r.status = bsa_pkg::ST_MISMATCH;
            end
            else
            begin
                for (int i = 0; i < bsa_pkg::SLOTS_DEFAULT && s < 0; i++)
                    if (free_map[i])
                        s = i;
                if (s < 0)
                begin
                    r.status = bsa_pkg::ST_FULL;
                end
                else
                begin
                    free_map[s] = 1'b0;
                    free_total--;
                    r.slot    = bsa_pkg::SLOT_FIELD_W'(s);
                    offset    = 64'(base_address) + 64'(s) * 64'(slot_bytes);
                    r.granted = offset[bsa_pkg::ADDR_W-1:0];
                end
            end
        end
        else
        begin
            span = 64'(bsa_pkg::SLOTS_DEFAULT) * 64'(slot_bytes);
            if (slot_bytes == '0 || 64'(addr) < 64'(base_address)
                || 64'(addr) - 64'(base_address) >= span)
            begin
                r.status = bsa_pkg::ST_INVALID;
            end
            else
            begin
                offset = (64'(addr) - 64'(base_address)) / 64'(slot_bytes);
                s      = int'(offset);
                if (free_map[s])
                begin
                    r.status = bsa_pkg::ST_DOUBLE;
                end
                else
                begin
                    free_map[s] = 1'b1;
                    free_total++;
                    r.slot = bsa_pkg::SLOT_FIELD_W'(s);
                end
            end
        end
        r.free_slots = bsa_pkg::FREE_FIELD_W'(free_total);
        awaited.push_back(r);
    endfunction

    function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field_name, want, got);
        end
    endfunction

    function void check_result(logic [bsa_pkg::OUT_TDATA_W-1:0] word);
        pool_result_t want;
        pool_result_t got;
        got.status     = word[bsa_pkg::OUT_STATUS_LSB +: bsa_pkg::STATUS_W];
        got.granted    = word[bsa_pkg::OUT_GRANT_LSB +: bsa_pkg::ADDR_W];
        got.slot       = word[bsa_pkg::OUT_SLOT_LSB +: bsa_pkg::SLOT_FIELD_W];
        got.free_slots = word[bsa_pkg::OUT_FREE_LSB +: bsa_pkg::FREE_FIELD_W];
        if (awaited.size() == 0)
        begin
            errors++;
            $display("%0t: result word expected none actual %h", $time, word);
            return;
        end
        want = awaited.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("granted_address", 64'(want.granted), 64'(got.granted));
        compare_field("slot_index", 64'(want.slot), 64'(got.slot));
        compare_field("free_slots", 64'(want.free_slots), 64'(got.free_slots));
    endfunction
endclass

module tb_top;

    // The slowest request is an allocate scanning the whole bitmap, and up to
    // four requests can sit inside the core at once.
    localparam int DRAIN_CYCLES = 40;
    // Length of the deliberate result-side hold-off that backs the core up.
    localparam int HOLD_CYCLES  = 300;
    // Cycles with no word moving on either stream before the run is declared
    // hung. The longest legal quiet stretch is the hold-off plus a few
    // requests' worth of work, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 2000;
    localparam logic [63:0] TOP_BASE = 64'h0000_FFFF_FFFF_FFFF;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bsa_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bsa_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_we;
    logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data;

    // quiet turns idling off on both streams; hold_request asks the result
    // side for one long hold-off.
    bit                     quiet;
    bit                     hold_request;
    int unsigned            stall_cycles;
    pool_checker            pool;

    bitmap_slot_allocator_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one request word, possibly after a random gap, and holds it until
    // the core takes it. The prediction is made at the accepting edge so that
    // the next generated request already sees the updated pool.
    task automatic send_request(input logic op, input logic [bsa_pkg::SIZE_W-1:0] size,
                                input logic [bsa_pkg::ADDR_W-1:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(bsa_pkg::IN_TDATA_W - bsa_pkg::IN_USED_W){1'b0}}, addr, size};
        do @(posedge clk); while (!s_tready);
        pool.note_request(op, size, addr);
    endtask

    // Rewrites both registers once every owed result has come back and the
    // core has had time to settle. The upper bits of the size word carry
    // junk that the register must drop.
    task automatic set_pool(input logic [bsa_pkg::BASE_W-1:0] base,
                            input logic [bsa_pkg::SIZE_W-1:0] size);
        logic [bsa_pkg::CFG_DATA_W-1:0] size_word;
        s_tvalid <= 1'b0;
        while (pool.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        size_word                      = bsa_pkg::CFG_DATA_W'({$urandom, $urandom});
        size_word[bsa_pkg::SIZE_W-1:0] = size;
        cfg_we    <= 1'b1;
        cfg_index <= bsa_pkg::CFG_BASE_ADDRESS;
        cfg_data  <= base;
        @(posedge clk);
        pool.write_reg(bsa_pkg::CFG_BASE_ADDRESS, base);
        cfg_index <= bsa_pkg::CFG_SLOT_BYTES;
        cfg_data  <= size_word;
        @(posedge clk);
        pool.write_reg(bsa_pkg::CFG_SLOT_BYTES, size_word);
        cfg_we <= 1'b0;
    endtask

    // Builds one random request. Allocates mostly ask for the served size;
    // frees mostly hand back an address inside a slot that is in use, with
    // a share of pool edges and fully random addresses mixed in.
    task automatic random_request(input int alloc_pct);
        logic                        op;
        logic [bsa_pkg::SIZE_W-1:0]  size;
        logic [bsa_pkg::ADDR_W-1:0]  addr;
        logic [63:0]                 span;
        logic [63:0]                 spot;
        int                          s;
        size = bsa_pkg::SIZE_W'($urandom);
        addr = bsa_pkg::ADDR_W'({$urandom, $urandom});
        spot = 64'(addr);
        span = 64'(bsa_pkg::SLOTS_DEFAULT) * 64'(pool.slot_bytes);
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            op = bsa_pkg::OP_ALLOC;
            case ($urandom_range(0, 11))
                0: ;
                1: size = pool.slot_bytes + 16'd1;
                2: size = pool.slot_bytes - 16'd1;
                default: size = pool.slot_bytes;
            endcase
        end
        else
        begin
            op = bsa_pkg::OP_FREE;
            case ($urandom_range(0, 11))
                0: ;
                1: spot = 64'(pool.base_address) - 64'd1;
                2: spot = 64'(pool.base_address) + span;
                3: spot = 64'(pool.base_address) + span - 64'd1;
                default:
                begin
                    // A few probes for a slot in use; a miss gives a double free.
                    s = $urandom_range(0, bsa_pkg::SLOTS_DEFAULT - 1);
                    for (int k = 0; k < 16 && pool.free_map[s]; k++)
                        s = $urandom_range(0, bsa_pkg::SLOTS_DEFAULT - 1);
                    spot = 64'(pool.base_address) + 64'(s) * 64'(pool.slot_bytes);
                    if (pool.slot_bytes != '0)
                        spot = spot + 64'($urandom_range(0, pool.slot_bytes - 1));
                end
            endcase
            addr = spot[bsa_pkg::ADDR_W-1:0];
        end
        send_request(op, size, addr);
    endtask

    // A run of random requests. Idling is switched on or off for stretches
    // of 80 words, or kept off for the whole run.
    task automatic run_phase(input int count, input int alloc_pct, input bit idle_ok);
        for (int i = 0; i < count; i++)
        begin
            if (!idle_ok)
                quiet = 1'b1;
            else if (i % 80 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            random_request(alloc_pct);
        end
    endtask

    // Result side: ready with random stall bursts, plus one long hold-off on
    // request, during which the core's queue fills and request intake stops.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Every result word that moves is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pool.check_result(m_tdata);
    end

    // Hang detection: counts edges at which no word moves on either stream.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        pool      = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= bsa_pkg::OP_ALLOC;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= bsa_pkg::CFG_BASE_ADDRESS;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: base 0, 64-byte slots, every slot free.
        // Size mismatches at both ends of the size field.
        send_request(bsa_pkg::OP_ALLOC, 16'd0, '0);
        send_request(bsa_pkg::OP_ALLOC, 16'hFFFF, '1);
        // First-fit grants of slots 0 and 1.
        send_request(bsa_pkg::OP_ALLOC, 16'd64, '0);
        send_request(bsa_pkg::OP_ALLOC, 16'd64, '0);
        // Release slot 0, then release it again.
        send_request(bsa_pkg::OP_FREE, 16'd0, 49'd0);
        send_request(bsa_pkg::OP_FREE, 16'd0, 49'd0);
        // The last byte of slot 1 releases slot 1.
        send_request(bsa_pkg::OP_FREE, 16'd0, 49'd127);
        // Just past the pool end, the last byte of the pool, the top address.
        send_request(bsa_pkg::OP_FREE, 16'd0, 49'd32768);
        send_request(bsa_pkg::OP_FREE, 16'd0, 49'd32767);
        send_request(bsa_pkg::OP_FREE, 16'hFFFF, '1);
        send_request(bsa_pkg::OP_ALLOC, 16'd64, '0);

        // Highest base and largest slots; the pool reaches past bit 47, so
        // valid addresses carry the top address bit.
        set_pool(TOP_BASE[bsa_pkg::BASE_W-1:0], 16'hFFFF);
        send_request(bsa_pkg::OP_FREE, 16'd0, bsa_pkg::ADDR_W'(TOP_BASE - 64'd1));
        send_request(bsa_pkg::OP_ALLOC, 16'hFFFF, '0);
        send_request(bsa_pkg::OP_ALLOC, 16'hFFFE, '0);
        send_request(bsa_pkg::OP_FREE, 16'd0, bsa_pkg::ADDR_W'(TOP_BASE + 64'd65635));
        send_request(bsa_pkg::OP_FREE, 16'd0,
                     bsa_pkg::ADDR_W'(TOP_BASE + 64'd512 * 64'd65535 - 64'd1));
        send_request(bsa_pkg::OP_FREE, 16'd0,
                     bsa_pkg::ADDR_W'(TOP_BASE + 64'd512 * 64'd65535));
        send_request(bsa_pkg::OP_FREE, 16'd0, bsa_pkg::ADDR_W'(TOP_BASE));
        run_phase(300, 70, 1'b1);

        // One-byte slots with allocates dominating, so the pool runs full and
        // stays full for a while. The long result-side hold-off falls here.
        set_pool(bsa_pkg::BASE_W'({$urandom, $urandom}), 16'd1);
        hold_request = 1'b1;
        run_phase(700, 90, 1'b1);

        // Random slot size with frees dominating to drain the pool again.
        set_pool(bsa_pkg::BASE_W'({$urandom, $urandom}),
                 bsa_pkg::SIZE_W'($urandom_range(1, 16'hFFFF)));
        run_phase(450, 25, 1'b1);

        // Zero-sized slots: every free is out of range, and a zero-sized
        // allocate is granted the base address itself.
        set_pool(bsa_pkg::BASE_W'({$urandom, $urandom}), 16'd0);
        send_request(bsa_pkg::OP_ALLOC, 16'd0, '0);
        send_request(bsa_pkg::OP_FREE, 16'd0, bsa_pkg::ADDR_W'(pool.base_address));
        run_phase(60, 60, 1'b1);

        // Base 0 with small slots; the tail runs with both streams busy.
        set_pool('0, bsa_pkg::SIZE_W'($urandom_range(1, 256)));
        run_phase(200, 50, 1'b1);
        run_phase(200, 50, 1'b0);

        s_tvalid <= 1'b0;
        while (pool.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pool.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
design/bsa_pkg.sv
design/bsa_front.sv
design/bsa_queue.sv
design/bsa_back.sv
design/bitmap_slot_allocator_core.sv
design/bsa_checker.sv
verif/tb_top.sv
